>>> rtl/lfu_pkg.sv
// Shared constants and types for the LFU cache.
`timescale 1ns / 1ps
package lfu_pkg;
   localparam int ENTRIES    = 16;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 16;
   localparam int DATA_BITS  = 32;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CAP_BITS-1:0]   cap_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [DATA_BITS-1:0]  data_type;

   localparam count_type COUNT_MAX = '1;
   localparam cap_type   CAP_RESET = cap_type'(16);
   localparam cap_type   CAP_LIMIT = cap_type'(ENTRIES);
   localparam logic      MODE_GET  = 1'b0;
   localparam logic      MODE_PUT  = 1'b1;

   typedef struct packed {
      logic     mode;
      data_type key;
      data_type value;
   } req_type;

   typedef struct packed {
      logic     hit;
      data_type read_value;
      logic     evicted;
      data_type evicted_key;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic scan;
      logic evict;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic need_evict;
      logic scan_last;
   } status_type;
endpackage

>>> rtl/lfu_cache_top.sv
// Top level of the LFU cache with least-recently-used tie-break.
//
// Requests arrive on req_valid/req_stall/req_data: a get (mode 0) looks a key
// up, a put (mode 1) stores a key/value pair. Each request gives one response
// on rsp_valid/rsp_stall/rsp_data with hit, read_value, evicted, evicted_key.
// A request is taken when valid is high and stall is low.
// A request that needs no eviction goes from match straight to update; a put
// that evicts first runs a victim search that walks the 16 entries one per
// cycle, then an evict step. One request is in work at a time; the next one
// is accepted on the cycle after its response is loaded.
// The response sits in an output register, so a request can be accepted while
// the previous response still waits; if the receiver stalls, the request in
// work holds before its final update until the register frees up.
// csr_we/csr_wdata write the capacity register; write it only while idle.
// Synchronous reset empties the cache and sets the capacity to 16.
`timescale 1ns / 1ps
module lfu_cache_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lfu_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lfu_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  lfu_pkg::cap_type       csr_wdata
);
   lfu_pkg::cmd_type    cmd;
   lfu_pkg::status_type status;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );
endmodule

>>> rtl/lfu_ctrl.sv
// Sequencer for one cache request: match, victim scan, evict, update.
`timescale 1ns / 1ps
module lfu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lfu_pkg::status_type status,
   output lfu_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_MATCH, ST_SCAN, ST_EVICT, ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.match   = (state_ff == ST_MATCH);
      cmd.scan    = (state_ff == ST_SCAN);
      cmd.evict   = (state_ff == ST_EVICT);
      cmd.update  = (state_ff == ST_UPDATE) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = status.need_evict ? ST_SCAN : ST_UPDATE;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> rtl/lfu_dp.sv
// Entry store, key match, victim scan and entry update for the LFU cache.
`timescale 1ns / 1ps
module lfu_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  lfu_pkg::cmd_type     cmd,
   input  lfu_pkg::req_type     req_data,
   input  logic                 csr_we,
   input  lfu_pkg::cap_type     csr_wdata,
   output lfu_pkg::status_type  status,
   output lfu_pkg::rsp_type     rsp_data
);
   localparam int N = lfu_pkg::ENTRIES;

   lfu_pkg::cap_type   cap_ff, cap_eff;
   logic               valid_ff [N];
   logic               valid_in [N];
   lfu_pkg::idx_type   rank_ff  [N];
   lfu_pkg::idx_type   rank_in  [N];
   lfu_pkg::data_type  key_ff   [N];
   lfu_pkg::data_type  key_in   [N];
   lfu_pkg::data_type  val_ff   [N];
   lfu_pkg::data_type  val_in   [N];
   lfu_pkg::count_type cnt_ff   [N];
   lfu_pkg::count_type cnt_in   [N];
   lfu_pkg::cap_type   occ_ff, occ_in;

   lfu_pkg::req_type   req_ff;
   logic               hit_ff, best_found_ff, evd_ff;
   lfu_pkg::idx_type   hit_idx_ff, scan_idx_ff, best_idx_ff;
   lfu_pkg::count_type best_cnt_ff;
   lfu_pkg::idx_type   best_rank_ff;
   lfu_pkg::data_type  evd_key_ff;
   lfu_pkg::rsp_type   rsp_ff, rsp_in;

   logic               hit_any, free_found, better;
   lfu_pkg::idx_type   hit_idx, free_idx, old_rank;

   assign cap_eff = (cap_ff > lfu_pkg::CAP_LIMIT) ? lfu_pkg::CAP_LIMIT : cap_ff;
   assign rsp_data = rsp_ff;
   // The eviction decision is read by the controller during the match cycle itself.
   assign status.need_evict = (req_ff.mode == lfu_pkg::MODE_PUT) && !hit_any &&
                              (cap_eff != '0) && (occ_ff >= cap_eff);
   assign status.scan_last  = (scan_idx_ff == lfu_pkg::idx_type'(N - 1));

   // Parallel key compare and lowest free slot.
   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key) begin
            hit_any = 1'b1;
            hit_idx = lfu_pkg::idx_type'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = lfu_pkg::idx_type'(i);
         end
      end
   end

   assign better = valid_ff[scan_idx_ff] &&
      (!best_found_ff || cnt_ff[scan_idx_ff] < best_cnt_ff ||
       (cnt_ff[scan_idx_ff] == best_cnt_ff && rank_ff[scan_idx_ff] > best_rank_ff));
   assign old_rank = rank_ff[hit_idx_ff];

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      cnt_in   = cnt_ff;
      occ_in   = occ_ff;
      rsp_in   = rsp_ff;
      if (cmd.evict && best_found_ff) begin
         for (int i = 0; i < N; i++) begin
            if (valid_ff[i] && rank_ff[i] > rank_ff[best_idx_ff]) rank_in[i] = rank_ff[i] - 1'b1;
         end
         valid_in[best_idx_ff] = 1'b0;
         occ_in = occ_ff - 1'b1;
      end
      if (cmd.update) begin
         rsp_in = '0;
         if (hit_ff && (req_ff.mode == lfu_pkg::MODE_GET || cap_eff != '0)) begin
            // Hit: bump the count and make the entry the most recent.
            rsp_in.hit = 1'b1;
            if (req_ff.mode == lfu_pkg::MODE_GET) rsp_in.read_value = val_ff[hit_idx_ff];
            else val_in[hit_idx_ff] = req_ff.value;
            if (cnt_ff[hit_idx_ff] != lfu_pkg::COUNT_MAX) begin
               cnt_in[hit_idx_ff] = cnt_ff[hit_idx_ff] + 1'b1;
            end
            for (int i = 0; i < N; i++) begin
               if (valid_ff[i] && lfu_pkg::idx_type'(i) != hit_idx_ff && rank_ff[i] < old_rank) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[hit_idx_ff] = '0;
         end else if (req_ff.mode == lfu_pkg::MODE_PUT && cap_eff != '0) begin
            rsp_in.evicted     = evd_ff;
            rsp_in.evicted_key = evd_key_ff;
            if (free_found) begin
               for (int i = 0; i < N; i++) begin
                  if (valid_ff[i]) rank_in[i] = rank_ff[i] + 1'b1;
               end
               valid_in[free_idx] = 1'b1;
               key_in[free_idx]   = req_ff.key;
               val_in[free_idx]   = req_ff.value;
               cnt_in[free_idx]   = lfu_pkg::count_type'(1);
               rank_in[free_idx]  = '0;
               occ_in             = occ_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= lfu_pkg::CAP_RESET;
         occ_ff   <= '0;
         valid_ff <= '{default: 1'b0};
         rank_ff  <= '{default: '0};
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         occ_ff   <= occ_in;
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
      if (cmd.capture) req_ff <= req_data;
      if (cmd.match) begin
         hit_ff        <= hit_any;
         hit_idx_ff    <= hit_idx;
         scan_idx_ff   <= '0;
         best_found_ff <= 1'b0;
         evd_ff        <= 1'b0;
         evd_key_ff    <= '0;
      end
      if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= scan_idx_ff;
            best_cnt_ff   <= cnt_ff[scan_idx_ff];
            best_rank_ff  <= rank_ff[scan_idx_ff];
         end
      end
      if (cmd.evict && best_found_ff) begin
         evd_ff     <= 1'b1;
         evd_key_ff <= key_ff[best_idx_ff];
      end
   end
endmodule

>>> tb/tb_lfu_cache_top.sv
// Testbench for the LFU cache: directed and random requests checked against a behavioral cache.
`timescale 1ns / 1ps
module tb_lfu_cache_top;
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lfu_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lfu_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   lfu_pkg::cap_type  csr_wdata = '0;

   lfu_cache_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Behavioral copy of the cache state.
   lfu_pkg::cap_type   cap_reg;
   logic               slot_valid [lfu_pkg::ENTRIES];
   lfu_pkg::data_type  slot_key [lfu_pkg::ENTRIES];
   lfu_pkg::data_type  slot_value [lfu_pkg::ENTRIES];
   lfu_pkg::count_type slot_count [lfu_pkg::ENTRIES];
   int                 slot_age [lfu_pkg::ENTRIES];
   int                 fill;

   // Expected responses in request order.
   lfu_pkg::rsp_type   exp_fifo [16];
   logic [3:0]         exp_wr = '0;
   logic [3:0]         exp_rd = '0;
   int                 exp_count = 0;

   int                 mismatches = 0;
   int                 rsp_seen = 0;
   int                 evict_seen = 0;
   int                 hit_seen = 0;
   bit                 calm = 1'b0;
   int                 hold_cycles = 0;
   lfu_pkg::data_type  key_pool [64];
   int                 pool_size = 0;

   function automatic void exp_store(lfu_pkg::rsp_type r);
      exp_fifo[exp_wr] = r;
      exp_wr++;
      exp_count++;
   endfunction

   function automatic lfu_pkg::rsp_type exp_take();
      lfu_pkg::rsp_type r;
      r = exp_fifo[exp_rd];
      exp_rd++;
      exp_count--;
      return r;
   endfunction

   function automatic int lookup_slot(lfu_pkg::data_type k);
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
         if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void mark_recent(int s);
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
         if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
      slot_age[s] = 0;
      if (slot_count[s] != lfu_pkg::COUNT_MAX) slot_count[s]++;
   endfunction

   function automatic lfu_pkg::rsp_type cache_access(lfu_pkg::req_type r);
      lfu_pkg::rsp_type o;
      int      s;
      int      cap;
      int      v;
      o = '0;
      cap = (cap_reg > lfu_pkg::CAP_LIMIT) ? lfu_pkg::ENTRIES : int'(cap_reg);
      s = lookup_slot(r.key);
      if (r.mode == lfu_pkg::MODE_GET) begin
         if (s >= 0) begin
            mark_recent(s);
            o.hit = 1'b1;
            o.read_value = slot_value[s];
         end
         return o;
      end
      if (cap == 0) return o;
      if (s >= 0) begin
         slot_value[s] = r.value;
         mark_recent(s);
         o.hit = 1'b1;
         return o;
      end
      if (fill >= cap) begin
         v = -1;
         for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
                (slot_count[i] == slot_count[v] && slot_age[i] > slot_age[v]))) v = i;
         if (v >= 0) begin
            o.evicted = 1'b1;
            o.evicted_key = slot_key[v];
            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
               if (slot_valid[i] && slot_age[i] > slot_age[v]) slot_age[i]--;
            slot_valid[v] = 1'b0;
            fill--;
         end
      end
      s = -1;
      for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--)
         if (!slot_valid[i]) s = i;
      if (s < 0) return o;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
         if (slot_valid[i]) slot_age[i]++;
      slot_valid[s] = 1'b1;
      slot_key[s] = r.key;
      slot_value[s] = r.value;
      slot_count[s] = lfu_pkg::count_type'(1);
      slot_age[s] = 0;
      fill++;
      return o;
   endfunction

   // Valid stays high from one request to the next unless the sender idles.
   task automatic send_request(logic mode, lfu_pkg::data_type k, lfu_pkg::data_type v);
      if (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: mode, key: k, value: v};
      do @(posedge clock); while (req_stall);
      exp_store(cache_access(req_data));
      if (mode == lfu_pkg::MODE_PUT && pool_size < 64) begin
         key_pool[pool_size] = k;
         pool_size++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (exp_count != 0) @(negedge clock);
      // A put that evicts runs a victim search over every entry; let the block settle.
      repeat (30) @(negedge clock);
   endtask

   task automatic write_capacity(lfu_pkg::cap_type c);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= c;
      @(negedge clock);
      csr_we <= 1'b0;
      cap_reg = c;
   endtask

   function automatic lfu_pkg::data_type pick_key();
      if (pool_size != 0 && $urandom_range(99) < 70)
         return key_pool[$urandom_range(pool_size - 1)];
      return $urandom_range(40);
   endfunction

   // Receiver: sample at the rising edge, change stall at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (exp_count == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            lfu_pkg::rsp_type e;
            e = exp_take();
            if (e.evicted) evict_seen++;
            if (e.hit) hit_seen++;
            if (rsp_data.hit !== e.hit || rsp_data.read_value !== e.read_value ||
                rsp_data.evicted !== e.evicted || rsp_data.evicted_key !== e.evicted_key) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", e, rsp_data);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 17);
      end
   end

   task automatic test_directed();
      send_request(lfu_pkg::MODE_GET, 32'h0, 32'h0);
      send_request(lfu_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lfu_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(lfu_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h0);
      send_request(lfu_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(lfu_pkg::MODE_PUT, 32'h0, 32'hA5A5_5A5A);
      for (int i = 1; i <= 16; i++)
         send_request(lfu_pkg::MODE_PUT, lfu_pkg::data_type'(i), ~lfu_pkg::data_type'(i));
      send_request(lfu_pkg::MODE_GET, 32'h3, 32'h0);
      send_request(lfu_pkg::MODE_PUT, 32'h100, 32'h1);
   endtask

   task automatic test_capacity_edges();
      write_capacity(lfu_pkg::cap_type'(0));
      send_request(lfu_pkg::MODE_PUT, 32'h200, 32'h2);
      send_request(lfu_pkg::MODE_GET, 32'h3, 32'h0);
      write_capacity(lfu_pkg::cap_type'(31));
      send_request(lfu_pkg::MODE_PUT, 32'h201, 32'h3);
      write_capacity(lfu_pkg::cap_type'(1));
      send_request(lfu_pkg::MODE_PUT, 32'h202, 32'h4);
      send_request(lfu_pkg::MODE_PUT, 32'h203, 32'h5);
      write_capacity(lfu_pkg::cap_type'(16));
   endtask

   task automatic test_hot_key();
      // A heavily used key is followed by a stream of new keys.
      write_capacity(lfu_pkg::cap_type'(16));
      calm = 1'b1;
      send_request(lfu_pkg::MODE_PUT, 32'h5A5A, 32'h77);
      for (int i = 0; i < 30; i++) send_request(lfu_pkg::MODE_GET, 32'h5A5A, $urandom);
      for (int i = 0; i < 15; i++)
         send_request(lfu_pkg::MODE_PUT, 32'h7000_0000 + lfu_pkg::data_type'(i), $urandom);
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 200;
      for (int i = 0; i < 6; i++) send_request(lfu_pkg::MODE_PUT, $urandom_range(60), $urandom);
      wait_drained();
   endtask

   task automatic test_random();
      lfu_pkg::cap_type caps[6] = '{5'd16, 5'd4, 5'd0, 5'd2, 5'd31, 5'd9};
      for (int p = 0; p < 6; p++) begin
         write_capacity(caps[p]);
         calm = (p == 3);
         for (int i = 0; i < 270; i++) begin
            logic m;
            m = 1'($urandom_range(1));
            send_request(m, (i % 9 == 0) ? $urandom : pick_key(), $urandom);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      cap_reg = lfu_pkg::CAP_RESET;
      fill = 0;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_age[i] = 0;
         slot_count[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_capacity_edges();
      test_backpressure();
      test_random();
      test_hot_key();
      wait_drained();
      $display("Covered %0d responses: %0d hits, %0d evictions, capacities 0..31.",
               rsp_seen, hit_seen, evict_seen);
      if (mismatches == 0 && exp_count == 0) begin
         $display("lfu_cache_top verification clean");
      end else begin
         $display("%0d mismatches counted", mismatches);
         $display("lfu_cache_top verification failed");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("lfu_cache_top verification failed");
      $finish;
   end
endmodule

>>> filelist.f
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_top.sv
tb/tb_lfu_cache_top.sv
